/* rtl/bcd_pkg.sv */
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants of the button click event detector
// field widths, configuration register map and lane event record
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

  localparam int unsigned NumButtonsDefault = 11;

  localparam int unsigned FieldW = 11;
  localparam int unsigned TickW = 10;
  localparam int unsigned CntW = 11;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 48;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [FieldW-1:0] PolarityReset = 11'd2047;
  localparam logic [TickW-1:0] LongReset = 10'd200;
  localparam logic [TickW-1:0] ShortReset = 10'd5;
  localparam logic [TickW-1:0] WindowReset = 10'd50;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPolarity = 2'd0,
    CfgLong     = 2'd1,
    CfgShort    = 2'd2,
    CfgWindow   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] long_ticks;
    logic [TickW-1:0] short_ticks;
    logic [TickW-1:0] window_ticks;
  } lane_cfg_t;

  typedef struct packed {
    logic pressed;
    logic short_ev;
    logic double_ev;
    logic long_ev;
  } lane_evt_t;

  typedef struct packed {
    logic [FieldW-1:0] long_mask;
    logic [FieldW-1:0] double_mask;
    logic [FieldW-1:0] short_mask;
    logic [FieldW-1:0] pressed_mask;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/bcd_lane.sv */
// ----------------------------------------------------------------------------
// bcd_lane: per-button click detector
// tracks arm, hold and gap state of one button and flags its events per tick
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_lane (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  level_i,
  input  wire                  polarity_i,
  input  bcd_pkg::lane_cfg_t   cfg_i,
  output bcd_pkg::lane_evt_t   evt_o
);
  import bcd_pkg::*;

  logic            armed_q, armed_d;
  logic            last_q, last_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] hold_q, hold_d;
  logic [CntW-1:0] gap_q, gap_d;
  logic [CntW-1:0] hold_inc, gap_inc;
  logic            pressed;

  assign pressed  = (level_i == polarity_i);
  assign hold_inc = sat_inc(hold_q);
  assign gap_inc  = sat_inc(gap_q);

  always_comb begin
    armed_d = armed_q;
    last_d  = pressed;
    pend_d  = pend_q;
    hold_d  = hold_q;
    gap_d   = gap_q;
    evt_o   = '0;
    evt_o.pressed = pressed;
    if (pressed) begin
      if (armed_q) begin
        if (!last_q) begin
          hold_d = '0;
        end else begin
          hold_d = hold_inc;
          if (hold_inc > CntW'(cfg_i.long_ticks)) begin
            evt_o.long_ev = 1'b1;
            armed_d = 1'b0;
          end
        end
      end
    end else if (last_q) begin
      if ((hold_q < CntW'(cfg_i.long_ticks)) && (hold_q > CntW'(cfg_i.short_ticks))) begin
        hold_d = '0;
        gap_d  = '0;
        if (pend_q) begin
          pend_d = 1'b0;
          evt_o.double_ev = 1'b1;
        end else begin
          pend_d = 1'b1;
        end
      end
    end else begin
      armed_d = 1'b1;
      if (pend_q) begin
        gap_d = gap_inc;
        if (gap_inc > CntW'(cfg_i.window_ticks)) begin
          pend_d = 1'b0;
          gap_d  = '0;
          evt_o.short_ev = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      last_q  <= 1'b0;
      pend_q  <= 1'b0;
      hold_q  <= '0;
      gap_q   <= '0;
    end else if (en_i) begin
      armed_q <= armed_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
      hold_q  <= hold_d;
      gap_q   <= gap_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/bcd_merge.sv */
// ----------------------------------------------------------------------------
// bcd_merge: lane merge and output buffer
// gathers lane events into result masks and holds them in a two-entry skid
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_merge #(
  parameter int unsigned NUM_BUTTONS = bcd_pkg::NumButtonsDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  bcd_pkg::lane_evt_t   evt_i [NUM_BUTTONS],
  output logic                 ready_o,
  output logic                 valid_o,
  input  wire                  take_i,
  output bcd_pkg::result_t     result_o
);
  import bcd_pkg::*;

  result_t merged;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;

  for (genvar i = 0; i < FieldW; i++) begin : g_bit
    if (i < NUM_BUTTONS) begin : g_lane
      assign merged.pressed_mask[i] = evt_i[i].pressed;
      assign merged.short_mask[i]   = evt_i[i].short_ev;
      assign merged.double_mask[i]  = evt_i[i].double_ev;
      assign merged.long_mask[i]    = evt_i[i].long_ev;
    end else begin : g_pad
      assign merged.pressed_mask[i] = 1'b0;
      assign merged.short_mask[i]   = 1'b0;
      assign merged.double_mask[i]  = 1'b0;
      assign merged.long_mask[i]    = 1'b0;
    end
  end

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (!out_v_q || take_i) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = merged;
        skid_v_d = push_i;
      end else begin
        out_d   = merged;
        out_v_d = push_i;
      end
    end else if (push_i) begin
      skid_d   = merged;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o  = !skid_v_q;
  assign valid_o  = out_v_q;
  assign result_o = out_q;

endmodule

`default_nettype wire

/* rtl/button_click_event_detector_core.sv */
// ----------------------------------------------------------------------------
// button_click_event_detector_core: short, double and long press detector
// one lane per button updates on every scan tick; masks leave per tick
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         s_axis_tvalid/tready   tdata: levels
//  m_axis    out        m_axis_tvalid/tready   tdata: pressed, short, double, long
//  cfg       in         cfg_we_i               cfg_index_i, cfg_data_i
//
//  one scan tick per cycle while s_axis_tready is high; all lanes update in the cycle the tick is taken
//  each result is registered in the output entry, or in the skid entry while the output entry is busy
//  a two-entry output skid keeps input ready while only one result waits
//  reset clears all lane state and loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_event_detector_core #(
  parameter int unsigned NUM_BUTTONS = bcd_pkg::NumButtonsDefault
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire  [bcd_pkg::InDataW-1:0]   s_axis_tdata,   // levels[10:0]
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [bcd_pkg::OutDataW-1:0]  m_axis_tdata,   // pressed, short, double, long
  input  wire                           cfg_we_i,
  input  wire  [bcd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [bcd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bcd_pkg::*;

  logic [FieldW-1:0] polarity_q;
  lane_cfg_t         cfg_q;
  logic              accept;
  logic [FieldW-1:0] levels;
  lane_evt_t         evt [NUM_BUTTONS];
  result_t           result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      polarity_q         <= PolarityReset;
      cfg_q.long_ticks   <= LongReset;
      cfg_q.short_ticks  <= ShortReset;
      cfg_q.window_ticks <= WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPolarity: polarity_q         <= cfg_data_i[FieldW-1:0];
        CfgLong:     cfg_q.long_ticks   <= cfg_data_i[TickW-1:0];
        CfgShort:    cfg_q.short_ticks  <= cfg_data_i[TickW-1:0];
        CfgWindow:   cfg_q.window_ticks <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign levels = s_axis_tdata[FieldW-1:0];

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic lvl, pol;
    if (i < FieldW) begin : g_in
      assign lvl = levels[i];
      assign pol = polarity_q[i];
    end else begin : g_out
      assign lvl = 1'b0;
      assign pol = 1'b0;
    end
    bcd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .level_i    (lvl),
      .polarity_i (pol),
      .cfg_i      (cfg_q),
      .evt_o      (evt[i])
    );
  end

  bcd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (accept),
    .evt_i    (evt),
    .ready_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .take_i   (m_axis_tready),
    .result_o (result)
  );

  assign m_axis_tdata = {{(OutDataW - 4*FieldW){1'b0}}, result};

endmodule

`default_nettype wire
